### rtl/eight_bit_cpu_subset_executor_macros.svh
// assertion macros for the executor rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef EIGHT_BIT_CPU_SUBSET_EXECUTOR_MACROS_SVH
`define EIGHT_BIT_CPU_SUBSET_EXECUTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define ECSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ECSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ecse_pkg.sv
// package for the 8-bit cpu subset executor: opcodes, flag positions, beat structs
// no dependencies
`default_nettype none

package ecse_pkg;

  // opcodes without prefix
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_INC_C    = 8'h0C;
  localparam logic [7:0] OP_LD_C_N   = 8'h0E;
  localparam logic [7:0] OP_LD_DE_NN = 8'h11;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_SP_NN = 8'h31;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LD_A_N   = 8'h3E;
  localparam logic [7:0] OP_LD_C_A   = 8'h4F;
  localparam logic [7:0] OP_LD_HL_A  = 8'h77;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;

  // opcode after the prefix byte
  localparam logic [7:0] OP_CB_BIT7H = 8'h7C;

  // high-page base for ldh
  localparam logic [7:0] HIGH_PAGE = 8'hFF;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [7:0] opcode;
    logic       cb_prefixed;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] pointer_data;
    logic       write_ok;
  } in_beat_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [15:0] pointer_address;
    logic [4:0]  elapsed_cycles;
    logic [3:0]  flags;
    logic        halted;
    logic        last;
  } out_beat_t;

endpackage

`default_nettype wire

### rtl/ecse_in_if.sv
// instruction channel: valid/ready handshake and instruction payload
// no dependencies
`default_nettype none

interface ecse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic       cb_prefixed;
  logic [7:0] imm_low;
  logic [7:0] imm_high;
  logic [7:0] pointer_data;
  logic       write_ok;

  modport source (
    output valid, opcode, cb_prefixed, imm_low, imm_high, pointer_data, write_ok,
    input  ready
  );
  modport sink (
    input  valid, opcode, cb_prefixed, imm_low, imm_high, pointer_data, write_ok,
    output ready
  );
endinterface

`default_nettype wire

### rtl/ecse_out_if.sv
// result channel: valid/ready handshake and result payload
// no dependencies
`default_nettype none

interface ecse_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] next_pc;
  logic [15:0] pointer_address;
  logic [4:0]  elapsed_cycles;
  logic [3:0]  flags;
  logic        halted;
  logic        last;

  modport source (
    output valid, write_valid, write_address, write_data, next_pc, pointer_address,
           elapsed_cycles, flags, halted, last,
    input  ready
  );
  modport sink (
    input  valid, write_valid, write_address, write_data, next_pc, pointer_address,
           elapsed_cycles, flags, halted, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/eight_bit_cpu_subset_executor.sv
// top level of the 8-bit cpu subset executor
// depends on ecse_pkg, ecse_in_if, ecse_out_if, ecse_core, ecse_out_stage
`default_nettype none

// Executes one instruction per beat on in_i and returns its result beats on out_o.
// An instruction beat is held in an input register, decoded and executed
// combinationally against the architectural registers, and the result is held in
// an output register, so a result reaches out_o through the input register and
// then the output register. Every instruction gives one result beat, except CALL,
// which gives two beats (high then low byte of the return address); the execute
// stage is the only limit, so with out_o always ready the block takes a new
// instruction as soon as the previous one finishes. The block is not reset-swept:
// it accepts instructions from the first cycle after reset.
module eight_bit_cpu_subset_executor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ecse_in_if.sink   in_i,
  ecse_out_if.source out_o
);
  import ecse_pkg::*;

  logic      in_valid_q;
  in_beat_t  in_q;
  logic      item_done;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res_beat;
  out_beat_t out_beat;

  // input register frees up when its instruction finishes
  assign in_i.ready = !in_valid_q || item_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.opcode       <= in_i.opcode;
      in_q.cb_prefixed  <= in_i.cb_prefixed;
      in_q.imm_low      <= in_i.imm_low;
      in_q.imm_high     <= in_i.imm_high;
      in_q.pointer_data <= in_i.pointer_data;
      in_q.write_ok     <= in_i.write_ok;
    end
  end

  ecse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_beat),
    .item_done_o  (item_done)
  );

  ecse_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_beat),
    .res_ready_o (res_ready),
    .out_valid_o (out_o.valid),
    .out_beat_o  (out_beat),
    .out_ready_i (out_o.ready)
  );

  // unpack the result beat onto the channel
  assign out_o.write_valid     = out_beat.write_valid;
  assign out_o.write_address   = out_beat.write_address;
  assign out_o.write_data      = out_beat.write_data;
  assign out_o.next_pc         = out_beat.next_pc;
  assign out_o.pointer_address = out_beat.pointer_address;
  assign out_o.elapsed_cycles  = out_beat.elapsed_cycles;
  assign out_o.flags           = out_beat.flags;
  assign out_o.halted          = out_beat.halted;
  assign out_o.last            = out_beat.last;

endmodule

`default_nettype wire

### rtl/ecse_core.sv
// execute stage: architectural registers and single-pass instruction decode
// depends on ecse_pkg and eight_bit_cpu_subset_executor_macros.svh
`default_nettype none

`include "eight_bit_cpu_subset_executor_macros.svh"

module ecse_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire ecse_pkg::in_beat_t item_i,
  input  wire logic               res_ready_i,
  output logic                    res_valid_o,
  output ecse_pkg::out_beat_t     res_o,
  output logic                    item_done_o
);
  import ecse_pkg::*;

  logic [7:0]  acc_q, acc_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] bc_q, bc_d;
  logic [15:0] de_q, de_d;
  logic [15:0] hl_q, hl_d;
  logic [15:0] sp_q, sp_d;
  logic [15:0] pc_q, pc_d;
  logic        halt_q, halt_d;
  logic        push_lo_q;

  logic        fire;
  logic [15:0] nn;
  logic [15:0] ret_addr;
  logic [15:0] jr_offset;
  logic [7:0]  c_inc;
  logic        wv;
  logic [15:0] wa;
  logic [7:0]  wd;
  logic [4:0]  cyc;
  logic        last;

  assign nn        = {item_i.imm_high, item_i.imm_low};
  assign ret_addr  = pc_q + 16'd3;
  assign jr_offset = {{8{item_i.imm_low[7]}}, item_i.imm_low};
  assign c_inc     = bc_q[7:0] + 8'd1;

  // decode and execute one instruction
  always_comb begin
    acc_d   = acc_q;
    flags_d = flags_q;
    bc_d    = bc_q;
    de_d    = de_q;
    hl_d    = hl_q;
    sp_d    = sp_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    wv      = 1'b0;
    wa      = '0;
    wd      = '0;
    cyc     = '0;
    last    = 1'b1;
    if (halt_q) begin
      pc_d = pc_q + 16'd1;
      cyc  = 5'd4;
    end else if (item_i.cb_prefixed) begin
      if (item_i.opcode == OP_CB_BIT7H) begin
        pc_d    = pc_q + 16'd2;
        flags_d = '0;
        flags_d[FLAG_Z] = ~hl_q[15];
        flags_d[FLAG_H] = 1'b1;
        flags_d[FLAG_C] = flags_q[FLAG_C];
        cyc     = 5'd8;
      end else begin
        pc_d   = pc_q + 16'd1;
        halt_d = 1'b1;
      end
    end else begin
      case (item_i.opcode)
        OP_NOP: begin
          pc_d = pc_q + 16'd1;
          cyc  = 5'd4;
        end
        OP_LD_B_N: begin
          bc_d = {item_i.imm_low, bc_q[7:0]};
          pc_d = pc_q + 16'd2;
          cyc  = 5'd8;
        end
        OP_INC_C: begin
          flags_d = '0;
          flags_d[FLAG_Z] = (c_inc == 8'd0);
          flags_d[FLAG_H] = (bc_q[3:0] == 4'hF);
          flags_d[FLAG_C] = flags_q[FLAG_C];
          bc_d = {bc_q[15:8], c_inc};
          pc_d = pc_q + 16'd1;
          cyc  = 5'd4;
        end
        OP_LD_C_N: begin
          bc_d = {bc_q[15:8], item_i.imm_low};
          pc_d = pc_q + 16'd2;
          cyc  = 5'd8;
        end
        OP_LD_DE_NN: begin
          de_d = nn;
          pc_d = pc_q + 16'd3;
          cyc  = 5'd12;
        end
        OP_LD_A_DE: begin
          acc_d = item_i.pointer_data;
          pc_d  = pc_q + 16'd1;
          cyc   = 5'd8;
        end
        OP_JR_NZ: begin
          if (flags_q[FLAG_Z]) begin
            pc_d = pc_q + 16'd2;
            cyc  = 5'd8;
          end else begin
            pc_d = pc_q + 16'd2 + jr_offset;
            cyc  = 5'd12;
          end
        end
        OP_LD_HL_NN: begin
          hl_d = nn;
          pc_d = pc_q + 16'd3;
          cyc  = 5'd12;
        end
        OP_LD_SP_NN: begin
          sp_d = nn;
          pc_d = pc_q + 16'd3;
          cyc  = 5'd12;
        end
        OP_LDD_HL_A: begin
          wv   = 1'b1;
          wa   = hl_q;
          wd   = acc_q;
          pc_d = pc_q + 16'd1;
          if (item_i.write_ok) begin
            hl_d = hl_q - 16'd1;
            cyc  = 5'd8;
          end else begin
            halt_d = 1'b1;
          end
        end
        OP_LD_A_N: begin
          acc_d = item_i.imm_low;
          pc_d  = pc_q + 16'd2;
          cyc   = 5'd8;
        end
        OP_LD_C_A: begin
          bc_d = {bc_q[15:8], acc_q};
          pc_d = pc_q + 16'd1;
          cyc  = 5'd4;
        end
        OP_LD_HL_A: begin
          wv     = 1'b1;
          wa     = hl_q;
          wd     = acc_q;
          pc_d   = pc_q + 16'd1;
          cyc    = 5'd8;
          halt_d = ~item_i.write_ok;
        end
        OP_XOR_A: begin
          acc_d   = '0;
          flags_d = '0;
          flags_d[FLAG_Z] = 1'b1;
          pc_d    = pc_q + 16'd1;
          cyc     = 5'd4;
        end
        OP_LDH_N_A: begin
          wv     = 1'b1;
          wa     = {HIGH_PAGE, item_i.imm_low};
          wd     = acc_q;
          pc_d   = pc_q + 16'd2;
          cyc    = 5'd12;
          halt_d = ~item_i.write_ok;
        end
        OP_LDH_C_A: begin
          wv     = 1'b1;
          wa     = {HIGH_PAGE, bc_q[7:0]};
          wd     = acc_q;
          pc_d   = pc_q + 16'd1;
          cyc    = 5'd8;
          halt_d = ~item_i.write_ok;
        end
        OP_CALL: begin
          // high byte of the return address first, then the low byte
          pc_d = nn;
          sp_d = sp_q - 16'd2;
          wv   = 1'b1;
          if (push_lo_q) begin
            wa  = sp_q - 16'd2;
            wd  = ret_addr[7:0];
            cyc = 5'd24;
          end else begin
            wa   = sp_q - 16'd1;
            wd   = ret_addr[15:8];
            last = 1'b0;
          end
        end
        default: begin
          halt_d = 1'b1;
        end
      endcase
    end
  end

  // result beat reflects the state after the instruction
  always_comb begin
    res_o.write_valid     = wv;
    res_o.write_address   = wa;
    res_o.write_data      = wd;
    res_o.next_pc         = pc_d;
    res_o.pointer_address = de_d;
    res_o.elapsed_cycles  = cyc;
    res_o.flags           = flags_d;
    res_o.halted          = halt_d;
    res_o.last            = last;
  end

  assign fire        = item_valid_i && res_ready_i;
  assign res_valid_o = item_valid_i;
  assign item_done_o = fire && last;

  // architectural state commits on the final beat of an instruction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      flags_q   <= '0;
      bc_q      <= '0;
      de_q      <= '0;
      hl_q      <= '0;
      sp_q      <= '0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      push_lo_q <= 1'b0;
    end else if (fire) begin
      push_lo_q <= ~last;
      if (last) begin
        acc_q   <= acc_d;
        flags_q <= flags_d;
        bc_q    <= bc_d;
        de_q    <= de_d;
        hl_q    <= hl_d;
        sp_q    <= sp_d;
        pc_q    <= pc_d;
        halt_q  <= halt_d;
      end
    end
  end

  `ECSE_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halted core left the halted state")
  `ECSE_ASSERT_NOW(a_halted_beat, item_valid_i && halt_q,
                   !wv && cyc == 5'd4 && last, "halted core produced a non-idle beat")
  `ECSE_ASSERT_NEXT(a_push_follows, fire && !last, push_lo_q && !halt_q,
                    "first push beat not followed by the second push")
  `ECSE_ASSERT_NOW(a_no_write_zero, item_valid_i && !wv, wa == 16'd0 && wd == 8'd0,
                   "write fields not cleared on a beat without a write")

endmodule

`default_nettype wire

### rtl/ecse_out_stage.sv
// result register between the execute stage and the result channel
// depends on ecse_pkg
`default_nettype none

module ecse_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire ecse_pkg::out_beat_t res_i,
  output logic                     res_ready_o,
  output logic                     out_valid_o,
  output ecse_pkg::out_beat_t      out_beat_o,
  input  wire logic                out_ready_i
);
  import ecse_pkg::*;

  logic      valid_q;
  out_beat_t beat_q;

  // take a new beat when empty or when the held one leaves
  assign res_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      beat_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the 8-bit cpu subset executor
// uses ecse_pkg, ecse_in_if, ecse_out_if and the top level from the rtl folder
// predicts every result beat from a local model of the registers and checks each field

module tb_top;
  import ecse_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_INSTRS = 350;
  localparam int unsigned PRESSURE_INSTRS = 40;
  localparam int unsigned STALL_CYCLES  = 64;
  localparam int unsigned HALTED_INSTRS = 30;
  localparam int unsigned MAX_PRINTS    = 40;

  // ways to stop the core; only one can be exercised per run since halt is sticky
  typedef enum int unsigned {
    HALT_BAD_OPCODE,
    HALT_BAD_PREFIXED,
    HALT_LDD_REJECT,
    HALT_LD_HL_REJECT,
    HALT_LDH_N_REJECT,
    HALT_LDH_C_REJECT
  } halt_cause_e;

  logic clk_i;
  logic rst_ni;

  ecse_in_if  in_if ();
  ecse_out_if out_if ();

  eight_bit_cpu_subset_executor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // architectural state of the model
  logic [7:0]  reg_a;
  logic [3:0]  reg_f;
  logic [15:0] reg_bc;
  logic [15:0] reg_de;
  logic [15:0] reg_hl;
  logic [15:0] reg_sp;
  logic [15:0] reg_pc;
  logic        core_halted;

  out_beat_t   pending_results[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          idle_en;
  int unsigned hold_request;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eight_bit_cpu_subset_executor verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // one expected beat built from the current register state
  task automatic queue_result(input logic wv, input logic [15:0] wa, input logic [7:0] wd,
                              input logic [4:0] cyc, input logic lst);
    out_beat_t r;
    r.write_valid     = wv;
    r.write_address   = wa;
    r.write_data      = wd;
    r.next_pc         = reg_pc;
    r.pointer_address = reg_de;
    r.elapsed_cycles  = cyc;
    r.flags           = reg_f;
    r.halted          = core_halted;
    r.last            = lst;
    pending_results.push_back(r);
  endtask

  // executes one instruction on the model and queues its result beats
  task automatic exec_instr(input in_beat_t b);
    logic [15:0] nn;
    logic [15:0] ret_addr;
    logic [7:0]  c_old;
    logic        wv;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic [4:0]  cyc;
    nn  = {b.imm_high, b.imm_low};
    wv  = 1'b0;
    wa  = '0;
    wd  = '0;
    cyc = '0;
    if (core_halted) begin
      reg_pc = reg_pc + 16'd1;
      queue_result(1'b0, '0, '0, 5'd4, 1'b1);
    end else if (b.cb_prefixed) begin
      // prefix byte always counts, bit 7,h is the only prefixed op
      reg_pc = reg_pc + 16'd1;
      if (b.opcode == OP_CB_BIT7H) begin
        reg_pc = reg_pc + 16'd1;
        reg_f  = {~reg_hl[15], 1'b0, 1'b1, reg_f[FLAG_C]};
        cyc    = 5'd8;
      end else begin
        core_halted = 1'b1;
      end
      queue_result(1'b0, '0, '0, cyc, 1'b1);
    end else if (b.opcode == OP_CALL) begin
      // two pushes, high byte first; write_ok plays no part
      ret_addr    = reg_pc + 16'd3;
      reg_pc      = nn;
      reg_sp      = reg_sp - 16'd2;
      queue_result(1'b1, reg_sp + 16'd1, ret_addr[15:8], 5'd0, 1'b0);
      queue_result(1'b1, reg_sp, ret_addr[7:0], 5'd24, 1'b1);
    end else begin
      case (b.opcode)
        OP_NOP: begin
          reg_pc = reg_pc + 16'd1; cyc = 5'd4;
        end
        OP_LD_B_N: begin
          reg_bc[15:8] = b.imm_low; reg_pc = reg_pc + 16'd2; cyc = 5'd8;
        end
        OP_INC_C: begin
          c_old       = reg_bc[7:0];
          reg_f       = {(c_old == 8'hFF), 1'b0, (c_old[3:0] == 4'hF), reg_f[FLAG_C]};
          reg_bc[7:0] = c_old + 8'd1;
          reg_pc      = reg_pc + 16'd1;
          cyc         = 5'd4;
        end
        OP_LD_C_N: begin
          reg_bc[7:0] = b.imm_low; reg_pc = reg_pc + 16'd2; cyc = 5'd8;
        end
        OP_LD_DE_NN: begin
          reg_de = nn; reg_pc = reg_pc + 16'd3; cyc = 5'd12;
        end
        OP_LD_A_DE: begin
          reg_a = b.pointer_data; reg_pc = reg_pc + 16'd1; cyc = 5'd8;
        end
        OP_JR_NZ: begin
          if (reg_f[FLAG_Z]) begin
            reg_pc = reg_pc + 16'd2; cyc = 5'd8;
          end else begin
            reg_pc = reg_pc + 16'd2 + {{8{b.imm_low[7]}}, b.imm_low}; cyc = 5'd12;
          end
        end
        OP_LD_HL_NN: begin
          reg_hl = nn; reg_pc = reg_pc + 16'd3; cyc = 5'd12;
        end
        OP_LD_SP_NN: begin
          reg_sp = nn; reg_pc = reg_pc + 16'd3; cyc = 5'd12;
        end
        OP_LDD_HL_A: begin
          // a rejected store keeps hl and reports no cycles
          wv = 1'b1; wa = reg_hl; wd = reg_a; reg_pc = reg_pc + 16'd1;
          if (b.write_ok) begin
            reg_hl = reg_hl - 16'd1; cyc = 5'd8;
          end else begin
            core_halted = 1'b1;
          end
        end
        OP_LD_A_N: begin
          reg_a = b.imm_low; reg_pc = reg_pc + 16'd2; cyc = 5'd8;
        end
        OP_LD_C_A: begin
          reg_bc[7:0] = reg_a; reg_pc = reg_pc + 16'd1; cyc = 5'd4;
        end
        OP_LD_HL_A: begin
          wv = 1'b1; wa = reg_hl; wd = reg_a; reg_pc = reg_pc + 16'd1; cyc = 5'd8;
          if (!b.write_ok) core_halted = 1'b1;
        end
        OP_XOR_A: begin
          reg_a = '0; reg_f = 4'b1000; reg_pc = reg_pc + 16'd1; cyc = 5'd4;
        end
        OP_LDH_N_A: begin
          wv = 1'b1; wa = {HIGH_PAGE, b.imm_low}; wd = reg_a;
          reg_pc = reg_pc + 16'd2; cyc = 5'd12;
          if (!b.write_ok) core_halted = 1'b1;
        end
        OP_LDH_C_A: begin
          wv = 1'b1; wa = {HIGH_PAGE, reg_bc[7:0]}; wd = reg_a;
          reg_pc = reg_pc + 16'd1; cyc = 5'd8;
          if (!b.write_ok) core_halted = 1'b1;
        end
        default: begin
          // unknown opcode: pc stays put
          core_halted = 1'b1;
        end
      endcase
      queue_result(wv, wa, wd, cyc, 1'b1);
    end
  endtask

  function automatic in_beat_t make_instr(input logic [7:0] op, input logic cb,
                                          input logic [7:0] lo, input logic [7:0] hi,
                                          input logic [7:0] pd, input logic wok);
    in_beat_t b;
    b.opcode       = op;
    b.cb_prefixed  = cb;
    b.imm_low      = lo;
    b.imm_high     = hi;
    b.pointer_data = pd;
    b.write_ok     = wok;
    return b;
  endfunction

  // bytes lean toward the edges of the range
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 11))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      2:       v = 8'h80;
      3:       v = 8'h7F;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  function automatic logic is_known_op(input logic [7:0] op);
    case (op)
      OP_NOP, OP_LD_B_N, OP_INC_C, OP_LD_C_N, OP_LD_DE_NN, OP_LD_A_DE, OP_JR_NZ,
      OP_LD_HL_NN, OP_LD_SP_NN, OP_LDD_HL_A, OP_LD_A_N, OP_LD_C_A, OP_LD_HL_A,
      OP_XOR_A, OP_CALL, OP_LDH_N_A, OP_LDH_C_A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // a well-formed instruction that keeps the core running
  function automatic in_beat_t random_instr();
    in_beat_t b;
    b = make_instr(8'h00, 1'b0, pick_byte(), pick_byte(), pick_byte(),
                   1'($urandom_range(0, 1)));
    case ($urandom_range(0, 17))
      0:  b.opcode = OP_NOP;
      1:  b.opcode = OP_LD_B_N;
      2:  b.opcode = OP_INC_C;
      3:  b.opcode = OP_LD_C_N;
      4:  b.opcode = OP_LD_DE_NN;
      5:  b.opcode = OP_LD_A_DE;
      6:  b.opcode = OP_JR_NZ;
      7:  b.opcode = OP_LD_HL_NN;
      8:  b.opcode = OP_LD_SP_NN;
      9:  begin b.opcode = OP_LDD_HL_A; b.write_ok = 1'b1; end
      10: b.opcode = OP_LD_A_N;
      11: b.opcode = OP_LD_C_A;
      12: begin b.opcode = OP_LD_HL_A; b.write_ok = 1'b1; end
      13: b.opcode = OP_XOR_A;
      14: b.opcode = OP_CALL;
      15: begin b.opcode = OP_LDH_N_A; b.write_ok = 1'b1; end
      16: begin b.opcode = OP_LDH_C_A; b.write_ok = 1'b1; end
      default: begin b.opcode = OP_CB_BIT7H; b.cb_prefixed = 1'b1; end
    endcase
    return b;
  endfunction

  // offers one instruction beat and runs the model once it is taken
  task automatic send_instr(input in_beat_t b);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.opcode       <= b.opcode;
    in_if.cb_prefixed  <= b.cb_prefixed;
    in_if.imm_low      <= b.imm_low;
    in_if.imm_high     <= b.imm_high;
    in_if.pointer_data <= b.pointer_data;
    in_if.write_ok     <= b.write_ok;
    do @(posedge clk_i); while (!in_if.ready);
    exec_instr(b);
  endtask

  // stops offering and waits until every result beat has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side: random stalls per beat, plus long holds on request
  initial begin : result_sink
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = idle_en ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      while (hold_request > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        hold_request--;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", 16'h0, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.write_valid !== want.write_valid)
          report_mismatch("write_valid", 16'(out_if.write_valid), 16'(want.write_valid));
        if (out_if.write_address !== want.write_address)
          report_mismatch("write_address", out_if.write_address, want.write_address);
        if (out_if.write_data !== want.write_data)
          report_mismatch("write_data", 16'(out_if.write_data), 16'(want.write_data));
        if (out_if.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_if.next_pc, want.next_pc);
        if (out_if.pointer_address !== want.pointer_address)
          report_mismatch("pointer_address", out_if.pointer_address, want.pointer_address);
        if (out_if.elapsed_cycles !== want.elapsed_cycles)
          report_mismatch("elapsed_cycles", 16'(out_if.elapsed_cycles),
                          16'(want.elapsed_cycles));
        if (out_if.flags !== want.flags)
          report_mismatch("flags", 16'(out_if.flags), 16'(want.flags));
        if (out_if.halted !== want.halted)
          report_mismatch("halted", 16'(out_if.halted), 16'(want.halted));
        if (out_if.last !== want.last)
          report_mismatch("last", 16'(out_if.last), 16'(want.last));
      end
    end
  end

  // loads into a, b, c, de and sp, with extreme values
  task automatic test_register_loads();
    send_instr(make_instr(OP_NOP, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_instr(make_instr(OP_LD_B_N, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_A_N, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_C_A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_instr(make_instr(OP_LD_DE_NN, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_A_DE, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b1));
    send_instr(make_instr(OP_LD_SP_NN, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1));
  endtask

  // increment carries, bit test both ways, relative jump both ways
  task automatic test_flags_and_branches();
    send_instr(make_instr(OP_INC_C, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_INC_C, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_C_N, 1'b0, 8'h0F, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_INC_C, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_instr(make_instr(OP_XOR_A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_JR_NZ, 1'b0, 8'h7F, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_HL_NN, 1'b0, 8'hFF, 8'h7F, 8'h00, 1'b1));
    send_instr(make_instr(OP_CB_BIT7H, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_HL_NN, 1'b0, 8'h00, 8'h80, 8'h00, 1'b1));
    send_instr(make_instr(OP_CB_BIT7H, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_instr(make_instr(OP_JR_NZ, 1'b0, 8'h80, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_JR_NZ, 1'b0, 8'h7F, 8'h00, 8'h00, 1'b1));
  endtask

  // stores at wrapping addresses and calls with the stack pointer wrapping
  task automatic test_stores_and_calls();
    send_instr(make_instr(OP_LD_A_N, 1'b0, 8'hA5, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_HL_NN, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LDD_HL_A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_HL_A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LDH_N_A, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1));
    send_instr(make_instr(OP_LDH_C_A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_LD_SP_NN, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1));
    send_instr(make_instr(OP_CALL, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b0));
  endtask

  // result side held off while instructions keep coming, so the input stalls
  task automatic test_output_stall();
    idle_en      = 1'b0;
    hold_request = STALL_CYCLES;
    repeat (PRESSURE_INSTRS) send_instr(random_instr());
    wait_drained();
    idle_en = 1'b1;
  endtask

  // random well-formed programs, with and without idle cycles
  task automatic test_random_programs();
    for (int unsigned i = 0; i < RANDOM_INSTRS; i++) begin
      if (i % 50 == 0) idle_en = ($urandom_range(0, 2) != 0);
      send_instr(random_instr());
    end
    wait_drained();
    idle_en = 1'b1;
  endtask

  // stop the core one way, then feed arbitrary beats to the halted core
  task automatic test_halt();
    halt_cause_e cause;
    in_beat_t    b;
    cause = halt_cause_e'($urandom_range(0, 5));
    b = make_instr(8'h00, 1'b0, pick_byte(), pick_byte(), pick_byte(), 1'b0);
    case (cause)
      HALT_BAD_OPCODE: begin
        do b.opcode = 8'($urandom_range(0, 255)); while (is_known_op(b.opcode));
        b.write_ok = 1'($urandom_range(0, 1));
      end
      HALT_BAD_PREFIXED: begin
        b.cb_prefixed = 1'b1;
        do b.opcode = 8'($urandom_range(0, 255)); while (b.opcode == OP_CB_BIT7H);
        b.write_ok = 1'($urandom_range(0, 1));
      end
      HALT_LDD_REJECT:   b.opcode = OP_LDD_HL_A;
      HALT_LD_HL_REJECT: b.opcode = OP_LD_HL_A;
      HALT_LDH_N_REJECT: b.opcode = OP_LDH_N_A;
      default:           b.opcode = OP_LDH_C_A;
    endcase
    send_instr(b);
    repeat (HALTED_INSTRS) begin
      send_instr(make_instr(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = '0;
    in_if.cb_prefixed  = 1'b0;
    in_if.imm_low      = '0;
    in_if.imm_high     = '0;
    in_if.pointer_data = '0;
    in_if.write_ok     = 1'b0;
    reg_a        = '0;
    reg_f        = '0;
    reg_bc       = '0;
    reg_de       = '0;
    reg_hl       = '0;
    reg_sp       = '0;
    reg_pc       = '0;
    core_halted  = 1'b0;
    err_count    = 0;
    cycle_count  = 0;
    idle_en      = 1'b1;
    hold_request = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_loads();
    test_flags_and_branches();
    test_stores_and_calls();
    wait_drained();
    test_output_stall();
    test_random_programs();
    test_halt();

    if (err_count == 0) begin
      $display("eight_bit_cpu_subset_executor verification clean");
    end else begin
      $display("eight_bit_cpu_subset_executor verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ecse_pkg.sv
rtl/ecse_in_if.sv
rtl/ecse_out_if.sv
rtl/ecse_core.sv
rtl/ecse_out_stage.sv
rtl/eight_bit_cpu_subset_executor.sv
tb/tb_top.sv
